### hdl/lrss_pkg.sv
// Package with payload types, constants and fixed targets for the leg recovery sequencer.
package lrss_pkg;

    localparam int NUM_LEGS_DEF   = 4;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int STEP_BITS_DEF  = 18;
    localparam int NUM_CFG        = 8;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_BITS       = 16;
    localparam int HEIGHT_BITS    = 16;

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_ENTER  = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    localparam logic [1:0] PH_STAND = 2'd0;
    localparam logic [1:0] PH_FOLD  = 2'd1;
    localparam logic [1:0] PH_ROLL  = 2'd2;

    localparam logic [2:0] REG_STAND_RAMP  = 3'd0;
    localparam logic [2:0] REG_FOLD_RAMP   = 3'd1;
    localparam logic [2:0] REG_FOLD_SETTLE = 3'd2;
    localparam logic [2:0] REG_ROLL_RAMP   = 3'd3;
    localparam logic [2:0] REG_ROLL_SETTLE = 3'd4;
    localparam logic [2:0] REG_STAND_HIP   = 3'd5;
    localparam logic [2:0] REG_STAND_THIGH = 3'd6;
    localparam logic [2:0] REG_STAND_KNEE  = 3'd7;

    localparam logic signed [HEIGHT_BITS-1:0] STAND_H_LO = 16'sd820;
    localparam logic signed [HEIGHT_BITS-1:0] STAND_H_HI = 16'sd1843;
    localparam logic signed [HEIGHT_BITS-1:0] LOW_H      = 16'sd409;

    typedef struct packed {
        logic [1:0]                       mode;
        logic [1:0]                       leg;
        logic signed [ANGLE_BITS_DEF-1:0] hip_meas;
        logic signed [ANGLE_BITS_DEF-1:0] thigh_meas;
        logic signed [ANGLE_BITS_DEF-1:0] knee_meas;
        logic signed [HEIGHT_BITS-1:0]    trunk_height;
        logic                             upside_down;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                       out_leg;
        logic signed [ANGLE_BITS_DEF-1:0] hip_set;
        logic signed [ANGLE_BITS_DEF-1:0] thigh_set;
        logic signed [ANGLE_BITS_DEF-1:0] knee_set;
        logic [1:0]                       phase;
        logic                             last;
    } t_out_item;

    // Fixed joint target of a phase; joint 0 hip, 1 thigh, 2 knee.
    function automatic logic signed [31:0] fixed_target(logic [1:0] ph, logic odd,
                                                        logic [1:0] joint);
        logic signed [31:0] v;
        v = 32'sd0;
        if (ph == PH_ROLL) begin
            case (joint)
                2'd0:    v = odd ? 32'sd5325 : 32'sd6144;
                2'd1:    v = odd ? -32'sd12698 : -32'sd6554;
                default: v = 32'sd11346;
            endcase
        end else begin
            case (joint)
                2'd0:    v = 32'sd0;
                2'd1:    v = -32'sd5734;
                default: v = 32'sd11059;
            endcase
        end
        return v;
    endfunction

endpackage

### hdl/lrss_div.sv
// Shared restoring divider: signed dividend by unsigned 16-bit divisor, truncating.
module lrss_div #(
    parameter int NUM_BITS = 52
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [NUM_BITS-1:0]  i_num,
    input  logic [15:0]                 i_den,
    output logic                        o_done,
    output logic signed [NUM_BITS-1:0]  o_quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_q;
    logic [16:0]         r_rem;
    logic                r_neg;
    logic                r_busy;
    logic [CNT_BITS-1:0] r_cnt;
    logic [17:0]         w_trial;
    logic [16:0]         w_shift;

    assign w_shift = {r_rem[15:0], r_q[NUM_BITS-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(NUM_BITS);
                r_neg  <= i_num[NUM_BITS-1];
                r_q    <= i_num[NUM_BITS-1] ? NUM_BITS'(-i_num) : i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (w_trial[17]) begin
                    r_rem <= w_shift;
                    r_q   <= {r_q[NUM_BITS-2:0], 1'b0};
                end else begin
                    r_rem <= w_trial[16:0];
                    r_q   <= {r_q[NUM_BITS-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_neg ? NUM_BITS'(-r_q) : r_q;
endmodule

### hdl/lrss_datapath.sv
// Datapath: angle stores, configuration, step counter and interpolation arithmetic.
module lrss_datapath #(
    parameter int NUM_LEGS   = lrss_pkg::NUM_LEGS_DEF,
    parameter int ANGLE_BITS = lrss_pkg::ANGLE_BITS_DEF,
    parameter int STEP_BITS  = lrss_pkg::STEP_BITS_DEF,
    parameter int LEG_BITS   = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lrss_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [lrss_pkg::CFG_BITS-1:0]       i_cfg_data,
    input  lrss_pkg::t_in_item                  i_item,
    input  logic                                i_sample,
    input  logic                                i_enter,
    input  logic                                i_tick,
    input  logic                                i_abort,
    input  logic                                i_load_tgt,
    input  logic                                i_step_zero,
    input  logic                                i_step_inc,
    input  logic                                i_div_start,
    input  logic [LEG_BITS-1:0]                 i_leg,
    input  logic [1:0]                          i_joint,
    input  logic                                i_capture,
    output logic                                o_div_done,
    output logic [1:0]                          o_phase,
    output logic                                o_abort_cond,
    output logic                                o_end_cond,
    output logic signed [ANGLE_BITS-1:0]        o_hip,
    output logic signed [ANGLE_BITS-1:0]        o_thigh,
    output logic signed [ANGLE_BITS-1:0]        o_knee
);
    import lrss_pkg::*;

    localparam int NJ       = NUM_LEGS * 3;
    localparam int IDX_BITS  = $clog2(NJ);
    localparam int DIFF_BITS = ANGLE_BITS + 1;
    localparam int NUM_BITS  = DIFF_BITS + STEP_BITS + 1;
    localparam logic [STEP_BITS-1:0] STEP_MAX = '1;

    logic [15:0] r_cfg [NUM_CFG];
    logic signed [ANGLE_BITS-1:0] r_meas  [NJ];
    logic signed [ANGLE_BITS-1:0] r_start [NJ];
    logic [1:0]           r_phase;
    logic [STEP_BITS-1:0] r_step;
    logic signed [ANGLE_BITS-1:0] r_res [3];
    logic signed [HEIGHT_BITS-1:0] r_h;
    logic                 r_up;

    logic [15:0] w_ramp;
    logic signed [ANGLE_BITS-1:0] w_ini, w_fin;
    logic signed [DIFF_BITS-1:0]  w_diff;
    logic signed [NUM_BITS-1:0]   w_prod, w_quot;
    logic        w_use_fin;
    logic signed [ANGLE_BITS-1:0] w_val;
    logic [IDX_BITS-1:0] w_idx;
    logic [STEP_BITS+3:0] w_ramp7, w_step10;
    logic [STEP_BITS:0] w_sum;

    always_comb begin
        case (r_phase)
            PH_STAND: w_ramp = r_cfg[REG_STAND_RAMP];
            PH_ROLL:  w_ramp = r_cfg[REG_ROLL_RAMP];
            default:  w_ramp = r_cfg[REG_FOLD_RAMP];
        endcase
        w_idx = IDX_BITS'(i_leg * 3 + i_joint);
        w_ini = r_start[w_idx];
        if (r_phase == PH_STAND) begin
            case (i_joint)
                2'd0:    w_fin = ANGLE_BITS'($signed(r_cfg[REG_STAND_HIP]));
                2'd1:    w_fin = ANGLE_BITS'($signed(r_cfg[REG_STAND_THIGH]));
                default: w_fin = ANGLE_BITS'($signed(r_cfg[REG_STAND_KNEE]));
            endcase
        end else begin
            w_fin = ANGLE_BITS'(fixed_target(r_phase, i_leg[0], i_joint));
        end
        w_diff    = DIFF_BITS'(w_fin) - DIFF_BITS'(w_ini);
        w_prod    = NUM_BITS'(w_diff) * $signed({1'b0, r_step});
        w_use_fin = (w_ramp == 16'd0) ||
                    ((STEP_BITS+16)'(r_step) > (STEP_BITS+16)'(w_ramp));
        w_val     = w_use_fin ? w_fin : ANGLE_BITS'(NUM_BITS'(w_ini) + w_quot);
        w_ramp7   = (STEP_BITS+4)'(r_cfg[REG_STAND_RAMP]) * (STEP_BITS+4)'(7);
        w_step10  = (STEP_BITS+4)'(r_step) * (STEP_BITS+4)'(10);
        w_sum     = (STEP_BITS+1)'(r_phase == PH_ROLL ?
                    {1'b0, r_cfg[REG_ROLL_RAMP]} + r_cfg[REG_ROLL_SETTLE] :
                    {1'b0, r_cfg[REG_FOLD_RAMP]} + r_cfg[REG_FOLD_SETTLE]);
    end

    // Stand-up aborts once 10*step > 7*ramp, i.e. step > floor(ramp*0.7), and r_up or r_h <= LOW_H.
    assign o_abort_cond = (r_phase == PH_STAND) && (w_step10 > w_ramp7) &&
                          (r_up || (r_h <= LOW_H));
    // Stand-up never ends by itself; only an abort or a new enter leaves it.
    assign o_end_cond = (r_phase == PH_STAND) ? 1'b0 :
                        (r_phase == PH_ROLL)  ? ({1'b0, r_step} > w_sum)
                                              : ({1'b0, r_step} >= w_sum);
    assign o_phase = r_phase;

    lrss_div #(.NUM_BITS(NUM_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_div_start),
        .i_num   (w_prod),
        .i_den   (w_ramp),
        .o_done  (o_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= 16'd500;  r_cfg[1] <= 16'd1000; r_cfg[2] <= 16'd1000;
            r_cfg[3] <= 16'd150;  r_cfg[4] <= 16'd150;  r_cfg[5] <= 16'd0;
            r_cfg[6] <= 16'hF333; r_cfg[7] <= 16'd6554;
            for (int k = 0; k < NJ; k++) begin
                r_meas[k]  <= '0;
                r_start[k] <= '0;
            end
            r_phase <= PH_FOLD;
            r_step  <= '0;
            r_h     <= '0;
            r_up    <= 1'b0;
        end else begin
            if (i_cfg_we) r_cfg[i_cfg_idx] <= i_cfg_data;
            if (i_sample && (32'(i_item.leg) < NUM_LEGS)) begin
                r_meas[IDX_BITS'(i_item.leg * 3)]     <= ANGLE_BITS'(i_item.hip_meas);
                r_meas[IDX_BITS'(i_item.leg * 3 + 1)] <= ANGLE_BITS'(i_item.thigh_meas);
                r_meas[IDX_BITS'(i_item.leg * 3 + 2)] <= ANGLE_BITS'(i_item.knee_meas);
            end
            // The tick's height and flag are kept for the whole tick.
            if (i_tick) begin
                r_h  <= i_item.trunk_height;
                r_up <= i_item.upside_down;
            end
            if (i_enter) begin
                r_start <= r_meas;
                r_step  <= '0;
                r_phase <= (!i_item.upside_down && i_item.trunk_height >= STAND_H_LO &&
                            i_item.trunk_height <= STAND_H_HI) ? PH_STAND : PH_FOLD;
            end
            if (i_abort) begin
                r_start <= r_meas;
                r_phase <= PH_FOLD;
            end
            if (i_load_tgt) begin
                for (int k = 0; k < NJ; k++)
                    r_start[k] <= ANGLE_BITS'(fixed_target(r_phase, 1'((k / 3) % 2),
                                                           2'(k % 3)));
                r_phase <= (r_phase == PH_ROLL) ? PH_FOLD :
                           (r_up ? PH_ROLL : PH_STAND);
            end
            if (i_step_zero) r_step <= '0;
            else if (i_step_inc && r_step != STEP_MAX) r_step <= r_step + 1'b1;
            if (i_capture) r_res[i_joint] <= w_val;
        end
    end

    assign o_hip   = r_res[0];
    assign o_thigh = r_res[1];
    assign o_knee  = r_res[2];
endmodule

### hdl/lrss_ctrl.sv
// Controller: sequences samples, enters and ticks through the shared divider.
module lrss_ctrl #(
    parameter int NUM_LEGS = lrss_pkg::NUM_LEGS_DEF,
    parameter int LEG_BITS = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_mode,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic                 o_last,
    input  logic                 i_div_done,
    input  logic                 i_abort_cond,
    input  logic                 i_end_cond,
    output logic                 o_sample,
    output logic                 o_enter,
    output logic                 o_tick,
    output logic                 o_abort,
    output logic                 o_load_tgt,
    output logic                 o_step_zero,
    output logic                 o_step_inc,
    output logic                 o_div_start,
    output logic [LEG_BITS-1:0]  o_leg,
    output logic [1:0]           o_joint,
    output logic                 o_capture
);
    import lrss_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_DIV, S_WAIT, S_OUT, S_FIN} t_state;
    t_state r_state;
    logic   r_end;
    logic   w_acc;
    logic   w_eval;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_sample   = w_acc && (i_mode == MODE_SAMPLE);
    assign o_enter    = w_acc && (i_mode == MODE_ENTER);
    assign o_tick     = w_acc && (i_mode == MODE_TICK);
    assign w_eval     = (r_state == S_EVAL);
    assign o_abort    = w_eval && i_abort_cond;
    assign o_div_start = (r_state == S_DIV);
    assign o_capture  = (r_state == S_WAIT) && i_div_done;
    assign o_load_tgt = (r_state == S_FIN) && r_end;
    assign o_step_zero = o_abort || o_load_tgt;
    assign o_step_inc = (r_state == S_FIN) && !r_end;
    assign o_out_valid = (r_state == S_OUT);
    assign o_last     = (32'(o_leg) == NUM_LEGS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_leg   <= '0;
            o_joint <= '0;
            r_end   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (o_tick) r_state <= S_EVAL;
                S_EVAL: begin
                    o_leg   <= '0;
                    o_joint <= '0;
                    r_end   <= i_end_cond;
                    r_state <= i_abort_cond ? S_IDLE : S_DIV;
                end
                S_DIV:  r_state <= S_WAIT;
                S_WAIT: if (i_div_done) begin
                    if (o_joint == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        o_joint <= o_joint + 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_OUT: if (!i_out_stall) begin
                    o_joint <= '0;
                    if (o_last) begin
                        r_state <= S_FIN;
                    end else begin
                        o_leg   <= o_leg + 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_FIN:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hdl/leg_recovery_stand_sequencer.sv
// Top level of the leg recovery stand sequencer.
//  channel | direction | handshake
//  in      | input     | i_in_valid / o_in_stall, payload i_in_data
//  out     | output    | o_out_valid / i_out_stall, payload o_out_data
//  cfg     | input     | i_cfg_we, i_cfg_idx, i_cfg_data
// Samples, enters and ignored items are accepted in idle and leave the input free.
// A tick stalls the input while it makes NUM_LEGS*3 passes, twelve by default, through
// the one bit-per-cycle divider and sends one result per leg; an output stall makes
// the input stall last longer. An aborting tick stalls the input and gives no results.
// Reset is synchronous; results hold while the output is stalled.
module leg_recovery_stand_sequencer #(
    parameter int NUM_LEGS   = lrss_pkg::NUM_LEGS_DEF,
    parameter int STEP_BITS  = lrss_pkg::STEP_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lrss_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [lrss_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  lrss_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output lrss_pkg::t_out_item               o_out_data
);
    import lrss_pkg::*;
    localparam int LEG_BITS   = 2;
    localparam int ANGLE_BITS = ANGLE_BITS_DEF;

    logic s_sample, s_enter, s_tick, s_abort, s_load, s_zero, s_inc, s_start;
    logic s_done, s_acond, s_econd, s_cap, s_last;
    logic [LEG_BITS-1:0] s_leg;
    logic [1:0] s_joint, s_phase;
    logic signed [ANGLE_BITS-1:0] s_hip, s_thigh, s_knee;

    lrss_ctrl #(.NUM_LEGS(NUM_LEGS), .LEG_BITS(LEG_BITS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .i_mode(i_in_data.mode), .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid), .o_last(s_last), .i_div_done(s_done),
        .i_abort_cond(s_acond), .i_end_cond(s_econd), .o_sample(s_sample),
        .o_enter(s_enter), .o_tick(s_tick), .o_abort(s_abort), .o_load_tgt(s_load),
        .o_step_zero(s_zero), .o_step_inc(s_inc), .o_div_start(s_start),
        .o_leg(s_leg), .o_joint(s_joint), .o_capture(s_cap)
    );

    lrss_datapath #(.NUM_LEGS(NUM_LEGS), .ANGLE_BITS(ANGLE_BITS),
                    .STEP_BITS(STEP_BITS), .LEG_BITS(LEG_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_item(i_in_data), .i_sample(s_sample),
        .i_enter(s_enter), .i_tick(s_tick), .i_abort(s_abort), .i_load_tgt(s_load),
        .i_step_zero(s_zero), .i_step_inc(s_inc), .i_div_start(s_start),
        .i_leg(s_leg), .i_joint(s_joint), .i_capture(s_cap), .o_div_done(s_done),
        .o_phase(s_phase), .o_abort_cond(s_acond), .o_end_cond(s_econd),
        .o_hip(s_hip), .o_thigh(s_thigh), .o_knee(s_knee)
    );

    always_comb begin
        o_out_data.out_leg   = s_leg;
        o_out_data.hip_set   = s_hip;
        o_out_data.thigh_set = s_thigh;
        o_out_data.knee_set  = s_knee;
        o_out_data.phase     = s_phase;
        o_out_data.last      = s_last;
    end
endmodule
